// ----- hdl/urx_pkg.sv -----
// Shared types and constants for the UART receive ring with XON/XOFF.
// Holds beat structs, result kind codes, flow characters, register map and FSM states.
// No dependencies.
package urx_pkg;

  // Default ring depth, handed to the top level parameter.
  localparam int DEPTH_DEFAULT = 1024;

  // Field widths fixed by the interface.
  localparam int COUNT_W = 6;
  localparam int BSIZE_W = 11;

  // Largest read request honored; larger requests clamp to it.
  localparam logic [COUNT_W-1:0] MAX_READ = COUNT_W'(32);

  // Flow characters: XON is ctrl-Q, XOFF is ctrl-S.
  localparam logic [7:0] CHAR_XON  = 8'h11;
  localparam logic [7:0] CHAR_XOFF = 8'h13;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FLOW  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Input modes.
  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Register port: byte address 4*i, word index in paddr[2].
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_BUFFER_SIZE = 1'b0;
  localparam logic REG_FLOW_ENABLE = 1'b1;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(1024);

  typedef struct packed {
    logic               mode;
    logic [7:0]         rx_byte;
    logic [COUNT_W-1:0] read_count;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         value;
    logic               last;
    logic [COUNT_W-1:0] granted_count;
  } out_t;

  typedef struct packed {
    logic [BSIZE_W-1:0] buffer_size;
    logic               flow_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XON,
    ST_XOFF,
    ST_MARK,
    ST_DATA
  } state_t;

endpackage

// ----- hdl/urx_cfg.sv -----
// Configuration registers of the receive ring, behind an APB-style port.
// Depends on urx_pkg for the register map and the cfg_t struct.
module urx_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urx_pkg::CFG_AW-1:0]  paddr,
  input  logic [urx_pkg::CFG_DW-1:0]  pwdata,
  output logic [urx_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output urx_pkg::cfg_t               cfg
);
  import urx_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_size <= BSIZE_RESET;
      cfg.flow_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BUFFER_SIZE: cfg.buffer_size <= pwdata[BSIZE_W-1:0];
        REG_FLOW_ENABLE: cfg.flow_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUFFER_SIZE: prdata = CFG_DW'(cfg.buffer_size);
      REG_FLOW_ENABLE: prdata = CFG_DW'(cfg.flow_enable);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hdl/urx_ring_mem.sv -----
// Byte ring storage: one write port, one read port with registered data.
// Depends on urx_pkg for the default depth.
module urx_ring_mem #(
  parameter int DEPTH = urx_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  import urx_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/urx_ctrl.sv -----
// Ring control: indices, fill level, XOFF tracking and the read sequencer.
// Depends on urx_pkg; drives the ports of urx_ring_mem.
module urx_ctrl #(
  parameter int DEPTH = urx_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  urx_pkg::cfg_t            cfg,
  input  logic                     start,
  output logic                     busy,
  input  urx_pkg::in_t             item,
  output logic                     result_valid,
  output urx_pkg::out_t            result,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [7:0]               mem_wr_data,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [7:0]               mem_rd_data
);
  import urx_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > BSIZE_W) ? LW : BSIZE_W;
  localparam int MW = (LW > COUNT_W) ? LW : COUNT_W;

  state_t state, state_next;

  logic [IW-1:0]      write_index;
  logic [IW-1:0]      read_index, read_index_next;
  logic [LW-1:0]      fill_level;
  logic               xoff_pending;
  logic [COUNT_W-1:0] granted;
  logic [COUNT_W-1:0] remain;
  logic               xoff_due_q;
  logic               empty_q;

  logic [CW-1:0]      bs_ext;
  logic [LW-1:0]      size;
  logic               accept;
  logic               full;
  logic [COUNT_W-1:0] req_c;
  logic [COUNT_W-1:0] granted_now;
  logic               empty_now;
  logic               xon_due;
  logic               xoff_due;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [LW-1:0] sz);
    logic [LW-1:0] nx;
    nx = LW'(idx) + LW'(1);
    return (nx >= sz) ? '0 : IW'(nx);
  endfunction

  // Pick the result that follows an optional XON.
  function automatic state_t after_xon(input logic e, input logic x,
                                       input logic [COUNT_W-1:0] g);
    state_t s;
    if (e) s = ST_MARK;
    else if (x) s = ST_XOFF;
    else if (g == '0) s = ST_MARK;
    else s = ST_DATA;
    return s;
  endfunction

  // Clamp the configured size into [2, DEPTH].
  always_comb begin
    bs_ext = CW'(cfg.buffer_size);
    if (bs_ext < CW'(2)) begin
      size = LW'(2);
    end else if (bs_ext > CW'(DEPTH)) begin
      size = LW'(DEPTH);
    end else begin
      size = LW'(bs_ext);
    end
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;
  assign full   = (fill_level >= size);

  assign req_c       = (item.read_count > MAX_READ) ? MAX_READ : item.read_count;
  assign granted_now = (MW'(fill_level) < MW'(req_c)) ? COUNT_W'(fill_level) : req_c;
  assign empty_now   = (fill_level == '0);
  assign xon_due     = xoff_pending & (fill_level < (size >> 1));
  // fill > floor(2*size/3) exactly when 3*fill > 2*size.
  assign xoff_due    = cfg.flow_enable & ~empty_now &
                       (((LW+2)'(fill_level) + {1'b0, fill_level, 1'b0}) >
                        {1'b0, size, 1'b0});

  assign mem_wr_en   = accept & (item.mode == MODE_RX) & ~full;
  assign mem_wr_addr = write_index;
  assign mem_wr_data = item.rx_byte;

  // Prefetch: the read port always fetches the entry the next data beat shows.
  assign read_index_next = (state == ST_DATA) ? adv(read_index, size) : read_index;
  assign mem_rd_addr     = read_index_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.mode == MODE_READ) begin
          state_next = xon_due ? ST_XON : after_xon(empty_now, xoff_due, granted_now);
        end
      end
      ST_XON:  state_next = after_xon(empty_q, xoff_due_q, granted);
      ST_XOFF: state_next = (granted == '0) ? ST_MARK : ST_DATA;
      ST_MARK: state_next = ST_IDLE;
      ST_DATA: state_next = (remain == COUNT_W'(1)) ? ST_IDLE : ST_DATA;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid         = 1'b1;
    result.kind          = KIND_DATA;
    result.value         = '0;
    result.last          = 1'b0;
    result.granted_count = granted;
    unique case (state)
      ST_IDLE: begin
        result_valid         = 1'b0;
        result.granted_count = '0;
      end
      ST_XON: begin
        result.kind  = KIND_FLOW;
        result.value = CHAR_XON;
      end
      ST_XOFF: begin
        result.kind  = KIND_FLOW;
        result.value = CHAR_XOFF;
      end
      ST_MARK: begin
        result.kind          = KIND_EMPTY;
        result.last          = 1'b1;
        result.granted_count = '0;
      end
      ST_DATA: begin
        result.value = mem_rd_data;
        result.last  = (remain == COUNT_W'(1));
      end
      default: result_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_index  <= '0;
      read_index   <= '0;
      fill_level   <= '0;
      xoff_pending <= 1'b0;
      remain       <= '0;
    end else begin
      state      <= state_next;
      read_index <= read_index_next;
      if (state == ST_DATA) begin
        remain <= remain - COUNT_W'(1);
      end
      if (mem_wr_en) begin
        write_index <= adv(write_index, size);
        fill_level  <= fill_level + LW'(1);
      end
      if (accept && item.mode == MODE_READ) begin
        remain     <= granted_now;
        fill_level <= fill_level - LW'(granted_now);
        if (xoff_due) begin
          xoff_pending <= 1'b1;
        end else if (xon_due) begin
          xoff_pending <= 1'b0;
        end
      end
    end
  end

  // Per-read payload, held for the whole result sequence.
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_READ) begin
      granted    <= granted_now;
      xoff_due_q <= xoff_due;
      empty_q    <= empty_now;
    end
  end

endmodule

// ----- hdl/uart_rx_ring_with_xon_xoff.sv -----
// Top level of the UART receive ring with XON/XOFF software flow control.
// Depends on urx_pkg, urx_cfg, urx_ring_mem and urx_ctrl.
//
// A received byte (mode 0) is accepted whenever busy is low, written into the ring
// the same edge, and busy never rises for it; when the ring holds buffer_size bytes,
// clamped into 2 to DEPTH, the byte is dropped. A read request (mode 1) raises busy
// from the cycle after acceptance and emits its results one per cycle, back to back:
// an optional XON, an optional XOFF, then either the granted data bytes or a single
// empty marker, 1 to MAX_READ+1 results in all. Busy stays high through the last
// beat, and the next item is taken on the cycle after the last beat.
// Data beats stream at one per cycle because the ring memory's single read port is
// always pointed at the entry the next beat shows, so its registered output is ready
// when needed. Results cannot be stalled: each beat is valid for one cycle, marked by
// result_valid. The ring contents are not cleared at reset and no clearing pass runs;
// entries are only read after being written. Write buffer_size and flow_enable only
// while the block is idle.
module uart_rx_ring_with_xon_xoff #(
  parameter int DEPTH = urx_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  urx_pkg::in_t               item,
  // result channel
  output logic                       result_valid,
  output urx_pkg::out_t              result,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [urx_pkg::CFG_AW-1:0] paddr,
  input  logic [urx_pkg::CFG_DW-1:0] pwdata,
  output logic [urx_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import urx_pkg::*;

  localparam int IW = $clog2(DEPTH);

  cfg_t          cfg;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic [IW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  // Hold buffer_size and flow_enable.
  urx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Track indices and fill, sequence the beats of a read.
  urx_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  // Store the received bytes.
  urx_ring_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- hdl/urx_checker.sv -----
// Port-level checks of the receive ring's sequencing, bound to the top level.
// Depends on urx_pkg and uart_rx_ring_with_xon_xoff.
module urx_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input urx_pkg::in_t  item,
  input logic          result_valid,
  input urx_pkg::out_t result
);
  import urx_pkg::*;

  // A read always starts its beats on the next cycle.
  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == MODE_READ) |=> result_valid)
    else $error("read request gave no beat on the next cycle");

  // A received byte gives no beat and leaves the block free.
  a_rx_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == MODE_RX) |=> (!result_valid && !busy))
    else $error("received byte produced a beat or held busy");

  // A read runs without gaps until its last beat, then stops.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("gap inside a read sequence");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("beat after the last beat of a read");

  // The empty marker always closes the read and grants nothing.
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_EMPTY) |->
      (result.last && result.granted_count == '0))
    else $error("empty marker malformed");

endmodule

bind uart_rx_ring_with_xon_xoff urx_checker u_urx_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);

// ----- tb/sv/uart_rx_ring_with_xon_xoff_test.sv -----
// Self-checking testbench for the UART receive ring with XON/XOFF flow control.
// Drives item and register beats, predicts every result beat and checks it on arrival.
// Depends on urx_pkg and the uart_rx_ring_with_xon_xoff top level.
`timescale 1ns / 1ps

module uart_rx_ring_with_xon_xoff_test;
  import urx_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int IDX_W = $clog2(DEPTH);

  // Clock, reset and block ports; every input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t item = '0;
  logic result_valid;
  out_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // Item beats waiting to be offered, and result beats still owed by the block.
  in_t pending_beats[$];
  out_t due_results[$];

  // Shadow copy of the ring, its pointers and the register settings.
  logic [7:0] ring_copy[DEPTH];
  logic [IDX_W-1:0] wr_ptr = '0;
  logic [IDX_W-1:0] rd_ptr = '0;
  logic [BSIZE_W-1:0] fill_lvl = '0;
  logic xoff_owed = 1'b0;
  logic [BSIZE_W-1:0] cfg_size = BSIZE_RESET;
  logic cfg_flow = 1'b0;

  // Run bookkeeping.
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int xon_cnt = 0;
  int xoff_cnt = 0;
  int drops = 0;
  int gap_left = 0;
  bit no_gap = 1'b0;

  uart_rx_ring_with_xon_xoff #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_t make_result(logic [1:0] k, logic [7:0] v, logic l,
                                       logic [COUNT_W-1:0] g);
    out_t r;
    r.kind = k;
    r.value = v;
    r.last = l;
    r.granted_count = g;
    return r;
  endfunction

  function automatic in_t make_item(logic m, logic [7:0] b, logic [COUNT_W-1:0] n);
    in_t it;
    it.mode = m;
    it.rx_byte = b;
    it.read_count = n;
    return it;
  endfunction

  // Move a ring pointer forward; wrap to zero once it reaches or passes the size in use.
  // This also pulls back a pointer left beyond a size that has since shrunk.
  function automatic logic [IDX_W-1:0] step_index(logic [IDX_W-1:0] idx, int lim);
    return (int'(idx) + 1 >= lim) ? '0 : idx + 1'b1;
  endfunction

  // Apply one accepted item beat to the shadow ring and queue the result beats it owes.
  task automatic ring_apply(input in_t it);
    int lim;
    int lvl;
    int want;
    int grant;
    // Clamp the programmed size into 2..DEPTH.
    lim = (int'(cfg_size) < 2) ? 2 : (int'(cfg_size) > DEPTH) ? DEPTH : int'(cfg_size);
    if (it.mode == MODE_RX) begin
      // Store the byte, or drop it on a full ring; no result either way.
      if (int'(fill_lvl) < lim) begin
        ring_copy[wr_ptr] = it.rx_byte;
        wr_ptr = step_index(wr_ptr, lim);
        fill_lvl = fill_lvl + 1'b1;
      end else begin
        drops++;
      end
    end else begin
      // Sample the fill level once; clamp oversized requests.
      lvl = int'(fill_lvl);
      want = (it.read_count > MAX_READ) ? int'(MAX_READ) : int'(it.read_count);
      grant = (lvl < want) ? lvl : want;
      // Release the sender first when XOFF is outstanding and the ring is below half.
      if (xoff_owed && lvl < lim / 2) begin
        xoff_owed = 1'b0;
        xon_cnt++;
        due_results.push_back(make_result(KIND_FLOW, CHAR_XON, 1'b0, COUNT_W'(grant)));
      end
      if (lvl == 0) begin
        // Empty ring: never XOFF, just the marker.
        due_results.push_back(make_result(KIND_EMPTY, 8'h00, 1'b1, '0));
      end else begin
        if (cfg_flow && lvl > (2 * lim) / 3) begin
          xoff_owed = 1'b1;
          xoff_cnt++;
          due_results.push_back(make_result(KIND_FLOW, CHAR_XOFF, 1'b0, COUNT_W'(grant)));
        end
        if (grant == 0) begin
          // Zero request with data waiting: marker only, nothing consumed.
          due_results.push_back(make_result(KIND_EMPTY, 8'h00, 1'b1, '0));
        end else begin
          for (int i = 0; i < grant; i++) begin
            due_results.push_back(make_result(KIND_DATA, ring_copy[rd_ptr], i + 1 == grant,
                                              COUNT_W'(grant)));
            rd_ptr = step_index(rd_ptr, lim);
          end
          fill_lvl = fill_lvl - BSIZE_W'(grant);
        end
      end
    end
  endtask

  // Idle gap after a beat: mostly none or short, a few long; no gaps during gap-free stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gap || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Driver: offer queued items on start, predict each beat as it is taken.
  always @(posedge clk) begin : item_driver
    logic take;
    take = start && !busy;
    if (!rst) begin
      if (take) begin
        ring_apply(item);
        beats_sent++;
        // Switch between gappy and gap-free stretches now and then.
        if (beats_sent % 40 == 0) no_gap = ($urandom_range(2) == 0);
        gap_left = pick_gap();
      end
      if (start && !take) begin
        // Hold the current beat until the block takes it.
      end else if (gap_left == 0 && pending_beats.size() > 0) begin
        item <= pending_beats.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: every result beat must match the oldest prediction.
  always @(posedge clk) begin : result_monitor
    out_t want;
    if (!rst && result_valid) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat kind=%0d value=%02h last=%0d granted=%0d",
                 $time, result.kind, result.value, result.last, result.granted_count);
      end else begin
        want = due_results.pop_front();
        results_seen++;
        if (result.kind !== want.kind || result.value !== want.value ||
            result.last !== want.last || result.granted_count !== want.granted_count) begin
          errors++;
          $display("%0t: result mismatch expected kind=%0d value=%02h last=%0d granted=%0d",
                   $time, want.kind, want.value, want.last, want.granted_count);
          $display("%0t:                 actual kind=%0d value=%02h last=%0d granted=%0d",
                   $time, result.kind, result.value, result.last, result.granted_count);
        end
      end
    end
  end

  // One register beat: setup cycle, then access cycle until pready.
  task automatic reg_access(input logic idx, input logic wr, input logic [CFG_DW-1:0] data,
                            output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (wr) begin
      if (idx == REG_BUFFER_SIZE) cfg_size = data[BSIZE_W-1:0];
      else cfg_flow = data[0];
    end
  endtask

  task automatic reg_expect(input logic idx, input logic [CFG_DW-1:0] val);
    logic [CFG_DW-1:0] got;
    reg_access(idx, 1'b0, '0, got);
    if (got !== val) begin
      errors++;
      $display("%0t: register %0d read back expected %0h actual %0h", $time, idx, val, got);
    end
  endtask

  // Wait until every queued beat is taken and every predicted result has come, then let
  // the clock run on so a last received byte has surely landed.
  task automatic settle();
    do @(posedge clk);
    while (pending_beats.size() != 0 || start || busy || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Empty the ring so a new size never exposes an entry that was never written.
  task automatic drain_ring();
    settle();
    while (fill_lvl != 0) begin
      pending_beats.push_back(make_item(MODE_READ, 8'($urandom), MAX_READ));
      settle();
    end
  endtask

  task automatic set_mode(input int size, input bit flow);
    logic [CFG_DW-1:0] unused;
    drain_ring();
    reg_access(REG_BUFFER_SIZE, 1'b1, CFG_DW'(size), unused);
    reg_access(REG_FLOW_ENABLE, 1'b1, CFG_DW'(flow), unused);
    reg_expect(REG_BUFFER_SIZE, CFG_DW'(size) & CFG_DW'(11'h7FF));
    reg_expect(REG_FLOW_ENABLE, CFG_DW'(flow));
    settings_used++;
  endtask

  function automatic in_t rand_item(int rx_pct, int max_cnt);
    logic [COUNT_W-1:0] n;
    n = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(63))
                                 : COUNT_W'($urandom_range(max_cnt));
    return make_item(($urandom_range(99) < rx_pct) ? MODE_RX : MODE_READ, 8'($urandom), n);
  endfunction

  // Random bursts, each mostly filling, churning or draining the ring.
  task automatic random_bursts(input int total, input int max_cnt);
    int left;
    int len;
    int rx_pct;
    left = total;
    while (left > 0) begin
      len = $urandom_range(30, 5);
      case ($urandom_range(2))
        0: rx_pct = 90;
        1: rx_pct = 50;
        default: rx_pct = 15;
      endcase
      repeat (len) pending_beats.push_back(rand_item(rx_pct, max_cnt));
      left -= len;
    end
  endtask

  task automatic push_rx(input logic [7:0] b);
    pending_beats.push_back(make_item(MODE_RX, b, COUNT_W'($urandom)));
  endtask

  task automatic push_read(input logic [COUNT_W-1:0] n);
    pending_beats.push_back(make_item(MODE_READ, 8'($urandom), n));
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values of both registers.
    reg_expect(REG_BUFFER_SIZE, CFG_DW'(BSIZE_RESET));
    reg_expect(REG_FLOW_ENABLE, '0);
    settings_used++;

    // Defaults: empty reads, zero request with data, oversized request.
    push_read(6'd0);
    push_read(6'd5);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(8'hAA);
    push_rx(8'h55);
    push_read(6'd0);
    push_read(6'd63);
    push_read(6'd1);

    // Tiny ring with flow control: drop on full, XOFF, exact wrap, XON, marker.
    set_mode(3, 1'b1);
    push_rx(8'h01);
    push_rx(8'h80);
    push_rx(8'h7F);
    push_rx(8'hFE);
    push_read(6'd1);
    push_read(6'd0);
    push_read(6'd2);
    push_read(6'd3);
    push_rx(8'h3C);
    push_rx(8'hC3);
    push_rx(8'h96);
    push_read(6'd0);
    push_read(6'd40);
    push_read(6'd1);

    // Random phases over several settings, clamped sizes among them.
    set_mode(2, 1'b1);
    random_bursts(60, 3);
    set_mode(0, 1'b1);
    random_bursts(50, 3);
    set_mode(17, 1'b1);
    random_bursts(70, 6);
    set_mode(100, 1'b1);
    random_bursts(70, 12);
    set_mode(5, 1'b0);
    random_bursts(50, 4);
    set_mode(1024, 1'b0);
    random_bursts(50, 32);

    // Oversized size register: acts as the full ring depth.
    set_mode(2047, 1'b1);
    random_bursts(50, 32);

    set_mode(7, 1'b1);
    random_bursts(60, 5);

    settle();
    repeat (16) @(posedge clk);
    $display("Run covered %0d item beats and %0d result beats over %0d register settings.",
             beats_sent, results_seen, settings_used);
    $display("Predicted %0d XON and %0d XOFF beats; %0d bytes dropped on a full ring.",
             xon_cnt, xoff_cnt, drops);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #3000000;
    $display("Timeout with %0d result beats still owed.", due_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/urx_pkg.sv
hdl/urx_cfg.sv
hdl/urx_ring_mem.sv
hdl/urx_ctrl.sv
hdl/uart_rx_ring_with_xon_xoff.sv
hdl/urx_checker.sv
tb/sv/uart_rx_ring_with_xon_xoff_test.sv
